[src/pixel_color_adjust_chain_top_macros.svh]
// Assertion helpers for the pixel color adjust chain.
// Both sample on the block clock and are off while reset is asserted.
`ifndef PIXEL_COLOR_ADJUST_CHAIN_TOP_MACROS_SVH
`define PIXEL_COLOR_ADJUST_CHAIN_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/pca_pkg.sv]
`default_nettype none

package pca_pkg;

    // Number of adjust stages in the chain.
    localparam int MAX_STAGES     = 4;
    // Fractional bits of the stage gains.
    localparam int GAIN_FRAC_BITS = 12;

    // Stages that the configuration registers can describe.
    localparam int REG_STAGES = 4;
    localparam int KIND_W     = 2;
    localparam int GAIN_W     = 16;
    localparam int KINDS_W    = REG_STAGES * KIND_W;
    localparam int GAINS_W    = REG_STAGES * GAIN_W;
    localparam int CHAN_W     = 8;

    // Opacity is Q1.12 regardless of the gain format.
    localparam int              OPAC_W      = 13;
    localparam int              OPAC_FRAC   = 12;
    localparam logic [OPAC_W-1:0] OPACITY_ONE = OPAC_W'(4096);

    // Configuration port.
    localparam int               CFG_IDX_W   = 2;
    localparam int               CFG_DATA_W  = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGE_KINDS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_STAGE_GAINS  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_OPACITY_GAIN = CFG_IDX_W'(2);

    // Stage arithmetic: 32 bits signed covers every gain format from 8 to 16
    // fractional bits.
    localparam int                      ACC_W    = 32;
    localparam logic signed [ACC_W-1:0] ONE_F    = ACC_W'(1 << GAIN_FRAC_BITS);
    localparam logic signed [ACC_W-1:0] MID_F    = ACC_W'(128 << GAIN_FRAC_BITS);
    localparam logic signed [ACC_W-1:0] CHAN_MAX = ACC_W'(255);
    localparam logic signed [8:0]       CHAN_MID = 9'sd128;

    // Luma weights and the divide by 1000 done as a reciprocal multiply.
    // ceil(2^28 / 1000) is exact for every weighted sum below 2^18.
    localparam int               SUM_W       = 18;
    localparam logic [SUM_W-1:0] W_RED       = SUM_W'(299);
    localparam logic [SUM_W-1:0] W_GREEN     = SUM_W'(587);
    localparam logic [SUM_W-1:0] W_BLUE      = SUM_W'(114);
    localparam int               RECIP_W     = 19;
    localparam int               RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'(268436);

    typedef enum logic [KIND_W-1:0] {
        KIND_PASS     = 2'd0,
        KIND_BRIGHT   = 2'd1,
        KIND_CONTRAST = 2'd2,
        KIND_SAT      = 2'd3
    } t_stage_kind;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              eof;
    } t_pix;

    // Code of one stage; stages past the register act as pass.
    function automatic t_stage_kind stage_kind(input logic [KINDS_W-1:0] kinds,
                                               input int idx);
        logic [KINDS_W-1:0] shifted;
        shifted = kinds >> (idx * KIND_W);
        return t_stage_kind'(shifted[KIND_W-1:0]);
    endfunction

    // Gain of one stage; stages past the register get zero.
    function automatic logic [GAIN_W-1:0] stage_gain(input logic [GAINS_W-1:0] gains,
                                                     input int idx);
        logic [GAINS_W-1:0] shifted;
        shifted = gains >> (idx * GAIN_W);
        return shifted[GAIN_W-1:0];
    endfunction

    // Divide by the gain scale, rounding toward zero.
    function automatic logic signed [ACC_W-1:0] div_trunc(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] res;
        if (v < 0) begin
            res = -((-v) >>> GAIN_FRAC_BITS);
        end else begin
            res = v >>> GAIN_FRAC_BITS;
        end
        return res;
    endfunction

    // Saturate to the channel range.
    function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [ACC_W-1:0] v);
        logic [CHAN_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > CHAN_MAX) begin
            res = '1;
        end else begin
            res = v[CHAN_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[src/pca_stage_cell.sv]
`default_nettype none

// One adjust stage: luma sum, luma divide, then the stage operation.
module pca_stage_cell import pca_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_stage_kind       i_kind,
    input  wire logic [GAIN_W-1:0] i_gain,
    input  wire logic              i_valid,
    input  wire t_pix              i_pix,
    output logic                   o_ready,
    output logic                   o_valid,
    output t_pix                   o_pix,
    input  wire logic              i_ready
);

    logic               r_a_valid, r_b_valid, r_c_valid;
    t_pix               r_a_pix, r_b_pix, r_c_pix;
    logic [SUM_W-1:0]   r_a_sum, n_a_sum;
    logic [CHAN_W-1:0]  r_b_gray, n_b_gray;
    t_pix               n_c_pix;
    logic               rdy_a, rdy_b, rdy_c;

    logic [SUM_W+RECIP_W-1:0]   quot_prod;
    logic signed [ACC_W-1:0]    bright_delta;
    logic [GAIN_W+1:0]          con_m;
    logic signed [ACC_W-1:0]    gray_f;
    logic [CHAN_W-1:0]          chan_in  [3];
    logic [CHAN_W-1:0]          chan_out [3];
    logic signed [ACC_W-1:0]    chan_s   [3];
    logic signed [8:0]          con_diff [3];
    logic signed [8:0]          sat_diff [3];
    logic signed [ACC_W-1:0]    con_acc  [3];
    logic signed [ACC_W-1:0]    sat_acc  [3];

    // A slot can load when it is empty or its content moves on.
    always_comb begin
        rdy_c   = !r_c_valid || i_ready;
        rdy_b   = !r_b_valid || rdy_c;
        rdy_a   = !r_a_valid || rdy_b;
        o_ready = rdy_a;
        o_valid = r_c_valid;
        o_pix   = r_c_pix;
    end

    // Weighted luma sum of the incoming pixel.
    always_comb begin
        n_a_sum = SUM_W'(i_pix.red) * W_RED + SUM_W'(i_pix.green) * W_GREEN
                + SUM_W'(i_pix.blue) * W_BLUE;
    end

    // Luma is the sum divided by 1000, by reciprocal multiply.
    always_comb begin
        quot_prod = (SUM_W+RECIP_W)'(r_a_sum) * (SUM_W+RECIP_W)'(RECIP_1000);
        n_b_gray  = quot_prod[RECIP_SHIFT +: CHAN_W];
    end

    // Stage operation on each channel.
    always_comb begin
        bright_delta = div_trunc($signed(ACC_W'(i_gain)) * CHAN_MAX - MID_F);
        con_m        = (GAIN_W+2)'(ONE_F) + ((GAIN_W+2)'(i_gain) << 1);
        gray_f       = $signed(ACC_W'(r_b_gray)) <<< GAIN_FRAC_BITS;
        chan_in[0]   = r_b_pix.red;
        chan_in[1]   = r_b_pix.green;
        chan_in[2]   = r_b_pix.blue;
        for (int i = 0; i < 3; i++) begin
            chan_s[i]   = $signed(ACC_W'(chan_in[i]));
            con_diff[i] = $signed({1'b0, chan_in[i]}) - CHAN_MID;
            sat_diff[i] = $signed({1'b0, chan_in[i]}) - $signed({1'b0, r_b_gray});
            con_acc[i]  = ACC_W'(con_diff[i] * $signed({1'b0, con_m})) + MID_F;
            sat_acc[i]  = ACC_W'(sat_diff[i] * $signed({1'b0, i_gain})) + gray_f;
            case (i_kind)
                KIND_BRIGHT:   chan_out[i] = clamp_chan(chan_s[i] + bright_delta);
                KIND_CONTRAST: chan_out[i] = clamp_chan(div_trunc(con_acc[i]));
                KIND_SAT:      chan_out[i] = clamp_chan(div_trunc(sat_acc[i]));
                default:       chan_out[i] = chan_in[i];
            endcase
        end
        n_c_pix.red   = chan_out[0];
        n_c_pix.green = chan_out[1];
        n_c_pix.blue  = chan_out[2];
        n_c_pix.eof   = r_b_pix.eof;
    end

    // Slot occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (rdy_a) r_a_valid <= i_valid;
            if (rdy_b) r_b_valid <= r_a_valid;
            if (rdy_c) r_c_valid <= r_b_valid;
        end
    end

    // Slot payload.
    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_pix <= i_pix;
            r_a_sum <= n_a_sum;
        end
        if (rdy_b) begin
            r_b_pix  <= r_a_pix;
            r_b_gray <= n_b_gray;
        end
        if (rdy_c) begin
            r_c_pix <= n_c_pix;
        end
    end

endmodule

`default_nettype wire

[src/pca_opacity_cell.sv]
`default_nettype none

// Final opacity scale; its slot is the block's output register.
module pca_opacity_cell import pca_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [OPAC_W-1:0] i_opacity,
    input  wire logic              i_valid,
    input  wire t_pix              i_pix,
    output logic                   o_ready,
    output logic                   o_valid,
    output t_pix                   o_pix,
    input  wire logic              i_ready
);

    logic              r_valid;
    t_pix              r_pix, n_pix;
    logic              rdy;
    logic              do_scale;
    logic [CHAN_W-1:0] chan_in  [3];
    logic [CHAN_W-1:0] chan_out [3];
    logic [CHAN_W+OPAC_W-1:0] prod [3];

    always_comb begin
        rdy     = !r_valid || i_ready;
        o_ready = rdy;
        o_valid = r_valid;
        o_pix   = r_pix;
    end

    // Scale each channel when opacity is below one.
    always_comb begin
        do_scale   = i_opacity < OPACITY_ONE;
        chan_in[0] = i_pix.red;
        chan_in[1] = i_pix.green;
        chan_in[2] = i_pix.blue;
        for (int i = 0; i < 3; i++) begin
            prod[i] = (CHAN_W+OPAC_W)'(chan_in[i]) * (CHAN_W+OPAC_W)'(i_opacity);
            if (do_scale) begin
                chan_out[i] = prod[i][OPAC_FRAC +: CHAN_W];
            end else begin
                chan_out[i] = chan_in[i];
            end
        end
        n_pix.red   = chan_out[0];
        n_pix.green = chan_out[1];
        n_pix.blue  = chan_out[2];
        n_pix.eof   = i_pix.eof;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (rdy) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy) begin
            r_pix <= n_pix;
        end
    end

endmodule

`default_nettype wire

[src/pixel_color_adjust_chain_top.sv]
// Channel   | Dir | Handshake       | Payload
// ----------+-----+-----------------+--------------------------------------------------
// pixel in  | in  | i_valid/o_ready | i_red_in i_green_in i_blue_in i_end_of_frame_in
// pixel out | out | o_valid/i_ready | o_red_out o_green_out o_blue_out o_end_of_frame_out
// config    | in  | i_cfg_wr_en     | i_cfg_index i_cfg_data
//
// One pixel request is accepted every cycle unless a stalled output has filled the chain;
// the path holds three registers per stage cell plus the output register.
// Reset is synchronous and active low; it empties the pipeline and loads the
// register defaults. A stalled output only holds the slots that are occupied:
// empty slots keep filling, so requests are taken until the whole chain is full.
`default_nettype none

`include "pixel_color_adjust_chain_top_macros.svh"

module pixel_color_adjust_chain_top import pca_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [CHAN_W-1:0]     i_red_in,
    input  wire logic [CHAN_W-1:0]     i_green_in,
    input  wire logic [CHAN_W-1:0]     i_blue_in,
    input  wire logic                  i_end_of_frame_in,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [CHAN_W-1:0]          o_red_out,
    output logic [CHAN_W-1:0]          o_green_out,
    output logic [CHAN_W-1:0]          o_blue_out,
    output logic                       o_end_of_frame_out
);

    logic [KINDS_W-1:0] r_stage_kinds;
    logic [GAINS_W-1:0] r_stage_gains;
    logic [OPAC_W-1:0]  r_opacity_gain;

    t_pix               link_pix   [MAX_STAGES+1];
    logic [MAX_STAGES:0] link_valid;
    logic [MAX_STAGES:0] link_ready;
    t_pix               out_pix;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_kinds  <= '0;
            r_stage_gains  <= '0;
            r_opacity_gain <= OPACITY_ONE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_STAGE_KINDS:  r_stage_kinds  <= i_cfg_data[KINDS_W-1:0];
                CFG_STAGE_GAINS:  r_stage_gains  <= i_cfg_data[GAINS_W-1:0];
                CFG_OPACITY_GAIN: r_opacity_gain <= i_cfg_data[OPAC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input request enters the first link.
    always_comb begin
        link_valid[0]     = i_valid;
        link_pix[0].red   = i_red_in;
        link_pix[0].green = i_green_in;
        link_pix[0].blue  = i_blue_in;
        link_pix[0].eof   = i_end_of_frame_in;
        o_ready           = link_ready[0];
    end

    // Row of stage cells, one per adjust stage.
    for (genvar s = 0; s < MAX_STAGES; s++) begin : g_stage
        pca_stage_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_kind  (stage_kind(r_stage_kinds, s)),
            .i_gain  (stage_gain(r_stage_gains, s)),
            .i_valid (link_valid[s]),
            .i_pix   (link_pix[s]),
            .o_ready (link_ready[s]),
            .o_valid (link_valid[s+1]),
            .o_pix   (link_pix[s+1]),
            .i_ready (link_ready[s+1])
        );
    end

    // Opacity scale and output register.
    pca_opacity_cell u_opacity (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_opacity (r_opacity_gain),
        .i_valid   (link_valid[MAX_STAGES]),
        .i_pix     (link_pix[MAX_STAGES]),
        .o_ready   (link_ready[MAX_STAGES]),
        .o_valid   (o_valid),
        .o_pix     (out_pix),
        .i_ready   (i_ready)
    );

    always_comb begin
        o_red_out          = out_pix.red;
        o_green_out        = out_pix.green;
        o_blue_out         = out_pix.blue;
        o_end_of_frame_out = out_pix.eof;
    end

    // An empty output register lets the whole chain take a request.
    `PCA_ASSERT_SAME(a_empty_out_ready, !o_valid, o_ready, "chain stalled with empty output")
    // Downstream ready always reaches the input.
    `PCA_ASSERT_SAME(a_ready_chain, i_ready, o_ready, "ready lost inside the chain")
    // A taken result with nothing behind it leaves the output empty.
    `PCA_ASSERT_NEXT(a_output_drains, o_valid && i_ready && !link_valid[MAX_STAGES], !o_valid, "result repeated on the output")

endmodule

`default_nettype wire
